// ===== rtl/ihc_pkg.sv =====
// Shared types, verdict codes and the ones' complement adder for the IPv4 header check.
// Used by every module of the core; depends on nothing.
package ihc_pkg;

    localparam logic [2:0] VERDICT_ACCEPT      = 3'd0;
    localparam logic [2:0] VERDICT_TTL         = 3'd1;
    localparam logic [2:0] VERDICT_VERSION     = 3'd2;
    localparam logic [2:0] VERDICT_HEADER_LEN  = 3'd3;
    localparam logic [2:0] VERDICT_DESTINATION = 3'd4;
    localparam logic [2:0] VERDICT_CHECKSUM    = 3'd5;

    localparam logic [3:0]  IPV4_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
    localparam logic [15:0] SUM_GOOD         = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
    localparam logic [15:0] TTL_INDEX        = 16'd8;
    localparam logic [15:0] DEST_INDEX_FIRST = 16'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] packet_length;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  version_field;
        logic [3:0]  header_words;
        logic [7:0]  ttl_field;
        logic [31:0] destination_field;
        logic [15:0] header_sum;
        logic [15:0] packet_length;
    } summary_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/ihc_front.sv =====
// Byte parser: captures header fields and the header sum, and emits one summary per packet.
// Depends on ihc_pkg.
module ihc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ihc_pkg::in_item_t in_data,
    input  logic              queue_full,
    output logic              push,
    output ihc_pkg::summary_t push_data
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic [3:0]  version_field_reg, version_field_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ttl_field_reg, ttl_field_next;
    logic [31:0] destination_field_reg, destination_field_next;

    logic        accept;
    logic        is_first;
    logic [5:0]  header_limit;
    logic        in_header;
    logic        odd_byte;
    logic [15:0] addend;
    logic [15:0] sum_added;
    logic [15:0] sum_final;
    logic [15:0] count_inc;
    logic [7:0]  b;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign b        = in_data.data_byte;

    always_comb
    begin
        is_first          = (byte_count_reg == 16'd0);
        version_field_next = is_first ? b[7:4] : version_field_reg;
        header_words_next  = is_first ? b[3:0] : header_words_reg;
        ttl_field_next     = (byte_count_reg == ihc_pkg::TTL_INDEX) ? b : ttl_field_reg;

        destination_field_next = destination_field_reg;
        case (byte_count_reg)
            ihc_pkg::DEST_INDEX_FIRST:         destination_field_next[31:24] = b;
            ihc_pkg::DEST_INDEX_FIRST + 16'd1: destination_field_next[23:16] = b;
            ihc_pkg::DEST_INDEX_FIRST + 16'd2: destination_field_next[15:8]  = b;
            ihc_pkg::DEST_INDEX_FIRST + 16'd3: destination_field_next[7:0]   = b;
            default: ;
        endcase

        header_limit = {header_words_next, 2'b00};
        in_header    = byte_count_reg < {10'd0, header_limit};
        odd_byte     = byte_count_reg[0];
        addend       = odd_byte ? {high_byte_hold_reg, b} : {b, 8'd0};
        sum_added    = ihc_pkg::ones_add(running_sum_reg, addend);

        high_byte_hold_next = (in_header && !odd_byte) ? b : high_byte_hold_reg;
        running_sum_next    = (in_header && odd_byte) ? sum_added : running_sum_reg;
        sum_final = (in_header && (odd_byte || in_data.last_byte)) ? sum_added : running_sum_reg;

        count_inc = (byte_count_reg == ihc_pkg::COUNT_MAX) ? byte_count_reg
                                                            : byte_count_reg + 16'd1;
        byte_count_next = count_inc;

        push = accept && in_data.last_byte;
        push_data.version_field     = version_field_next;
        push_data.header_words      = header_words_next;
        push_data.ttl_field         = ttl_field_next;
        push_data.destination_field = destination_field_next;
        push_data.header_sum        = sum_final;
        push_data.packet_length     = count_inc;

        if (in_data.last_byte)
        begin
            byte_count_next        = 16'd0;
            running_sum_next       = 16'd0;
            high_byte_hold_next    = 8'd0;
            version_field_next     = 4'd0;
            header_words_next      = 4'd0;
            ttl_field_next         = 8'd0;
            destination_field_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg        <= 16'd0;
            running_sum_reg       <= 16'd0;
            high_byte_hold_reg    <= 8'd0;
            version_field_reg     <= 4'd0;
            header_words_reg      <= 4'd0;
            ttl_field_reg         <= 8'd0;
            destination_field_reg <= 32'd0;
        end
        else if (accept)
        begin
            byte_count_reg        <= byte_count_next;
            running_sum_reg       <= running_sum_next;
            high_byte_hold_reg    <= high_byte_hold_next;
            version_field_reg     <= version_field_next;
            header_words_reg      <= header_words_next;
            ttl_field_reg         <= ttl_field_next;
            destination_field_reg <= destination_field_next;
        end
    end

endmodule

// ===== rtl/ihc_queue.sv =====
// Two-entry queue of packet summaries between the parser and the verdict stage.
// Depends on ihc_pkg.
module ihc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ihc_pkg::summary_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output ihc_pkg::summary_t head_data
);

    ihc_pkg::summary_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ihc_back.sv =====
// Verdict stage: holds the local address, ranks the checks and drives the output register.
// Depends on ihc_pkg.
module ihc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               head_valid,
    input  ihc_pkg::summary_t  head_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output ihc_pkg::out_item_t out_data
);

    logic [31:0]        local_address_reg;
    logic               out_valid_reg;
    ihc_pkg::out_item_t out_data_reg;
    logic               take;
    logic [2:0]         verdict;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take      = !out_valid_reg || !out_stall;
    assign pop       = head_valid && take;

    always_comb
    begin
        if (head_data.ttl_field == 8'd0)
            verdict = ihc_pkg::VERDICT_TTL;
        else if (head_data.version_field != ihc_pkg::IPV4_VERSION)
            verdict = ihc_pkg::VERDICT_VERSION;
        else if (head_data.header_words < ihc_pkg::MIN_HEADER_WORDS)
            verdict = ihc_pkg::VERDICT_HEADER_LEN;
        else if (head_data.destination_field != local_address_reg &&
                 head_data.destination_field != ihc_pkg::BROADCAST_ADDR)
            verdict = ihc_pkg::VERDICT_DESTINATION;
        else if (head_data.header_sum != ihc_pkg::SUM_GOOD)
            verdict = ihc_pkg::VERDICT_CHECKSUM;
        else
            verdict = ihc_pkg::VERDICT_ACCEPT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= 32'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_address_reg <= cfg_wdata;
            end
            if (take)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg.verdict       <= verdict;
            out_data_reg.packet_length <= head_data.packet_length;
        end
    end

endmodule

// ===== rtl/ipv4_header_check_core.sv =====
// Top level of the IPv4 receive header check: parser, summary queue and verdict stage.
// Depends on ihc_pkg, ihc_front, ihc_queue and ihc_back.
//
//   channel   direction  handshake            payload
//   in        receive    in_valid / in_stall  in_data   (data_byte, last_byte)
//   out       send       out_valid/out_stall  out_data  (verdict, packet_length)
//   cfg       receive    cfg_we               cfg_wdata (local_address)
//
// One byte is taken every cycle while in_stall is low; the per-byte path is a field
// capture and one 16-bit ones' complement add in the parser. The verdict reaches the
// output register through the summary queue. Reset clears all packet state and the
// local address at once. A two-entry summary queue and the output register absorb
// output stalls; input stall rises only when the queue is full.
module ipv4_header_check_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ihc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ihc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              head_valid;
    ihc_pkg::summary_t push_data;
    ihc_pkg::summary_t head_data;

    ihc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    ihc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ihc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
